FILE: rtl/swmed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmed_pkg: shared types and constants of the sliding window median filter
// Sample and result types, cell control bundle, sequencer states.
// ----------------------------------------------------------------------------
package swmed_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int SAMPLE_W       = 32;
    localparam int OUT_W          = 33;
    localparam int LEN_W          = 7;

    localparam logic [LEN_W-1:0] WLEN_RESET = 7'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [OUT_W-1:0]    median_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DROP
    } cell_op_t;

    // Broadcast from the sequencer to every cell of the sorted chain
    typedef struct packed {
        cell_op_t op;
        sample_t  sample;
        sample_t  victim;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DROP,
        ST_SELECT,
        ST_SUM
    } seq_state_t;

endpackage

FILE: rtl/swmed_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmed_cell: one slot of the sorted chain
// Holds one sorted entry; on insert it keeps, takes the new sample or takes
// its left neighbor; on drop it keeps or takes its right neighbor.
// ----------------------------------------------------------------------------
module swmed_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                 aclk,
    input  swmed_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]        fill,
    input  swmed_pkg::sample_t   left_val,
    input  logic                 left_gt,
    input  swmed_pkg::sample_t   right_val,
    output swmed_pkg::sample_t   val,
    output logic                 gt
);
    import swmed_pkg::*;

    sample_t val_reg;
    sample_t val_next;
    logic    occupied;
    logic    ge_victim;

    // Empty slots act as larger than any sample
    assign occupied  = CW'(IDX) < fill;
    assign gt        = !occupied || (val_reg > ctrl.sample);
    assign ge_victim = val_reg >= ctrl.victim;
    assign val       = val_reg;

    // Shift right of the insert point, shift left from the removed entry on
    always_comb begin
        val_next = val_reg;
        unique case (ctrl.op)
            CELL_INSERT: begin
                if (gt) begin
                    val_next = left_gt ? left_val : ctrl.sample;
                end
            end
            CELL_DROP: begin
                if (ge_victim) begin
                    val_next = right_val;
                end
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

FILE: rtl/swmed_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmed_ring: arrival-order sample ring
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module swmed_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  swmed_pkg::sample_t wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output swmed_pkg::sample_t rd_data
);
    import swmed_pkg::*;

    sample_t ring_mem [DEPTH];
    sample_t rd_data_reg;

    // Write the newest sample, read the oldest
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sliding_window_median_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_top: sliding window median filter
// Keeps the last window_length samples in an arrival ring and in a sorted
// chain of cells; gives twice the median once the window is full.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------
//   input    | s_valid / s_ready     | s_sample, s_first_sample
//   result   | m_valid / m_ready     | m_median_x2
//   config   | cfg_we (no wait)      | cfg_wdata (window_length)
//
// One sample at a time: a sample is only inserted while the window fills,
// the fill step that completes it adds middle select and sum, and with a
// full window a sample takes ring read, chain drop, chain insert, middle
// select and sum. Each extra drop after shortening the window adds a ring
// read and a chain drop. Reset empties the window and sets window_length
// to 3; no clearing pass. A stalled result waits in the output register
// and holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
    parameter int MAX_WINDOW = swmed_pkg::MAX_WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  swmed_pkg::sample_t            s_sample,
    input  logic                          s_first_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output swmed_pkg::median_t            m_median_x2,
    input  logic                          cfg_we,
    input  logic [swmed_pkg::LEN_W-1:0]   cfg_wdata
);
    import swmed_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    seq_state_t     state_reg, state_next;
    logic [LEN_W-1:0] wlen_reg;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [IW-1:0]  optr_reg, optr_next;
    sample_t        sample_reg;
    sample_t        lo_reg, hi_reg;
    logic           m_valid_reg;
    median_t        m_data_reg;

    logic [CW-1:0]  len_eff;
    logic [IW:0]    wr_sum;
    logic [IW-1:0]  wr_addr;
    logic [IW-1:0]  optr_inc;
    logic [IW-1:0]  hi_idx, lo_idx;
    logic           accept;
    logic           ring_wr_en, ring_rd_en;
    sample_t        ring_rd_data;
    logic           out_load;
    cell_ctrl_t     ctrl;

    sample_t        cell_val [MAX_WINDOW];
    logic           cell_gt  [MAX_WINDOW];

    // Clamp the configured length to 1..MAX_WINDOW
    always_comb begin
        if (wlen_reg == '0) begin
            len_eff = CW'(1);
        end else if (int'(wlen_reg) > MAX_WINDOW) begin
            len_eff = CW'(MAX_WINDOW);
        end else begin
            len_eff = CW'(wlen_reg);
        end
    end

    // Ring addresses: newest slot behind the oldest, wrap at MAX_WINDOW
    assign wr_sum   = {1'b0, optr_reg} + (IW+1)'(fill_reg);
    assign wr_addr  = (wr_sum >= (IW+1)'(MAX_WINDOW)) ?
                      IW'(wr_sum - (IW+1)'(MAX_WINDOW)) : IW'(wr_sum);
    assign optr_inc = (optr_reg == IW'(MAX_WINDOW - 1)) ? '0 : optr_reg + 1'b1;

    // Middle entries of the sorted chain
    assign hi_idx = IW'(len_eff >> 1);
    assign lo_idx = len_eff[0] ? hi_idx : hi_idx - 1'b1;

    assign accept = s_valid && s_ready;

    // Next state and per-step controls
    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        optr_next   = optr_reg;
        s_ready     = 1'b0;
        ring_wr_en  = 1'b0;
        ring_rd_en  = 1'b0;
        out_load    = 1'b0;
        ctrl.op     = CELL_HOLD;
        ctrl.sample = sample_reg;
        ctrl.victim = ring_rd_data;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_first_sample) begin
                        fill_next = '0;
                        optr_next = '0;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (fill_reg >= len_eff) begin
                    ring_rd_en = 1'b1;
                    state_next = ST_DROP;
                end else begin
                    ctrl.op    = CELL_INSERT;
                    ring_wr_en = 1'b1;
                    fill_next  = fill_reg + 1'b1;
                    state_next = (fill_reg + 1'b1 == len_eff) ? ST_SELECT : ST_IDLE;
                end
            end
            ST_DROP: begin
                ctrl.op    = CELL_DROP;
                fill_next  = fill_reg - 1'b1;
                optr_next  = optr_inc;
                state_next = ST_CHECK;
            end
            ST_SELECT: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wlen_reg    <= WLEN_RESET;
            fill_reg    <= '0;
            optr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            optr_reg  <= optr_next;
            if (cfg_we) begin
                wlen_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
        end
        if (state_reg == ST_SELECT) begin
            lo_reg <= cell_val[lo_idx];
            hi_reg <= cell_val[hi_idx];
        end
        if (out_load) begin
            m_data_reg <= {lo_reg[SAMPLE_W-1], lo_reg} + {hi_reg[SAMPLE_W-1], hi_reg};
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_median_x2 = m_data_reg;

    swmed_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (IW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr_en),
        .wr_addr (wr_addr),
        .wr_data (sample_reg),
        .rd_en   (ring_rd_en),
        .rd_addr (optr_reg),
        .rd_data (ring_rd_data)
    );

    // Sorted chain, ascending from cell 0
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        sample_t left_val;
        logic    left_gt;
        sample_t right_val;

        if (g == 0) begin : g_first
            assign left_val = sample_reg;
            assign left_gt  = 1'b0;
        end else begin : g_mid
            assign left_val = cell_val[g-1];
            assign left_gt  = cell_gt[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_last
            assign right_val = cell_val[g];
        end else begin : g_inner
            assign right_val = cell_val[g+1];
        end

        swmed_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .fill      (fill_reg),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .val       (cell_val[g]),
            .gt        (cell_gt[g])
        );
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sliding window median filter
// Walks a table of directed samples and window lengths, then random phases
// at several window lengths. Every accepted sample is run through a local
// window model; each result transaction is matched against the oldest
// expected twice-median. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    import swmed_pkg::*;

    localparam int WIN_DEPTH = MAX_WINDOW_DEF;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CFG
    } row_kind_t;

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_VALUE
    } exp_kind_t;

    typedef struct {
        row_kind_t        kind;
        sample_t          smp;
        bit               first;
        logic [LEN_W-1:0] wlen;
        exp_kind_t        chk;
        median_t          want;
    } stim_row_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    sample_t          s_sample;
    logic             s_first_sample;
    logic             m_valid;
    logic             m_ready;
    median_t          m_median_x2;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    // Window model state
    logic [LEN_W-1:0] wlen_cfg;
    sample_t          sorted_win [WIN_DEPTH];
    sample_t          arrival_win [WIN_DEPTH];
    int unsigned      fill_n;
    int unsigned      head_ptr;

    median_t          median_x2_due [$];
    median_t          rx_want;
    int               mismatch_count = 0;
    int               rx_stall = 0;
    bit               rx_quiet = 1'b0;
    bit               tx_quiet = 1'b0;

    // Directed rows: extremes, zero, one, even and oversize lengths, flag, equal values
    stim_row_t directed_rows [30] = '{
        '{ROW_SAMPLE, 32'sd5,        1'b1, '0, EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, '0, EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, '0, EXP_VALUE, 33'sd10},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, '0, EXP_VALUE, 33'h0_FFFF_FFFE},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, '0, EXP_VALUE, 33'h0_FFFF_FFFE},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, '0, EXP_VALUE, 33'h1_0000_0000},
        // shorten a full window to an even length: min + max
        '{ROW_CFG,    '0,            1'b0, 7'd2,   EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, '0, EXP_VALUE, 33'h1_FFFF_FFFF},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, '0, EXP_VALUE, 33'h0_FFFF_FFFE},
        // zero length acts as one
        '{ROW_CFG,    '0,            1'b0, 7'd0,   EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'sd7,        1'b0, '0, EXP_VALUE, 33'sd14},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, '0, EXP_VALUE, 33'h1_FFFF_FFFE},
        // oversize length acts as the full depth
        '{ROW_CFG,    '0,            1'b0, 7'd127, EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'sd100,      1'b1, '0, EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'hFFFF_FF9C, 1'b0, '0, EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'sd0,        1'b0, '0, EXP_NONE,  '0},
        '{ROW_CFG,    '0,            1'b0, 7'd1,   EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'sd3,        1'b0, '0, EXP_VALUE, 33'sd6},
        // equal values in an even window
        '{ROW_CFG,    '0,            1'b0, 7'd4,   EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'sd1,        1'b1, '0, EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'sd1,        1'b0, '0, EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'sd1,        1'b0, '0, EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'sd1,        1'b0, '0, EXP_VALUE, 33'sd2},
        '{ROW_SAMPLE, 32'sd0,        1'b0, '0, EXP_MODEL, '0},
        // restart on a full window
        '{ROW_SAMPLE, 32'sd9,        1'b1, '0, EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'hAAAA_AAAA, 1'b0, '0, EXP_MODEL, '0},
        '{ROW_SAMPLE, 32'h5555_5555, 1'b0, '0, EXP_MODEL, '0},
        '{ROW_SAMPLE, 32'sd0,        1'b0, '0, EXP_MODEL, '0},
        '{ROW_CFG,    '0,            1'b0, 7'd3,   EXP_NONE,  '0},
        '{ROW_SAMPLE, 32'h1234_5678, 1'b0, '0, EXP_MODEL, '0}
    };

    logic [LEN_W-1:0] phase_lengths [10] = '{
        7'd64, 7'd127, 7'd1, 7'd0, 7'd2, 7'd63, 7'd65, 7'd5, 7'd16, 7'd33
    };

    sliding_window_median_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_first_sample (s_first_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_median_x2    (m_median_x2),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int unsigned active_length();
        int unsigned len;
        len = wlen_cfg;
        if (len == 0) len = 1;
        if (len > WIN_DEPTH) len = WIN_DEPTH;
        return len;
    endfunction

    // Advance the window model by one sample; flag and value of the result
    task automatic predict_window_median(input sample_t smp, input bit first,
                                         output bit has_res, output median_t res);
        int unsigned len;
        int unsigned pos;
        sample_t     victim;
        len = active_length();
        has_res = 1'b0;
        res = '0;
        if (first) begin
            fill_n = 0;
            head_ptr = 0;
        end
        // drop the oldest until there is room for the new sample
        while (fill_n >= len) begin
            victim = arrival_win[head_ptr];
            pos = 0;
            while (pos < fill_n && sorted_win[pos] != victim) pos++;
            if (pos >= fill_n) pos = fill_n - 1;
            for (; pos + 1 < fill_n; pos++) sorted_win[pos] = sorted_win[pos + 1];
            fill_n--;
            head_ptr = (head_ptr + 1) % WIN_DEPTH;
        end
        // insert after any equal entries
        pos = fill_n;
        while (pos > 0 && sorted_win[pos - 1] > smp) begin
            sorted_win[pos] = sorted_win[pos - 1];
            pos--;
        end
        sorted_win[pos] = smp;
        arrival_win[(head_ptr + fill_n) % WIN_DEPTH] = smp;
        fill_n++;
        if (fill_n >= len) begin
            has_res = 1'b1;
            if (len % 2 == 1)
                res = median_t'(sorted_win[len / 2]) + median_t'(sorted_win[len / 2]);
            else
                res = median_t'(sorted_win[len / 2 - 1]) + median_t'(sorted_win[len / 2]);
        end
    endtask

    function automatic int idle_length();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic sample_t draw_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'sd0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3: return sample_t'($urandom_range(0, 8)) - 32'sd4;
            default: return sample_t'($urandom());
        endcase
    endfunction

    // Hold the input until the transaction is taken, then log its result
    task automatic send_sample(input sample_t smp, input bit first,
                               input exp_kind_t chk, input median_t want);
        bit      got;
        median_t pred;
        s_sample       <= smp;
        s_first_sample <= first;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_window_median(smp, first, got, pred);
        case (chk)
            EXP_MODEL: if (got) median_x2_due.push_back(pred);
            EXP_VALUE: median_x2_due.push_back(want);
            default: ;
        endcase
    endtask

    task automatic idle_after_sample();
        int gap;
        if ($urandom_range(0, 59) == 0) tx_quiet = !tx_quiet;
        gap = (!tx_quiet && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drain the block, let a result-less step finish, then write the length
    task automatic write_window_length(input logic [LEN_W-1:0] value);
        s_valid <= 1'b0;
        while (median_x2_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        wlen_cfg  = value;
    endtask

    // Result side: check each transaction and stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (median_x2_due.size() == 0) begin
                    report_mismatch($sformatf("median_x2 %0d with none expected",
                                              m_median_x2));
                end else begin
                    rx_want = median_x2_due.pop_front();
                    if (m_median_x2 !== rx_want)
                        report_mismatch($sformatf("median_x2 %0d, expected %0d",
                                                  m_median_x2, rx_want));
                end
            end
            if ($urandom_range(0, 299) == 0) rx_quiet <= !rx_quiet;
            if (rx_stall > 0) begin
                m_ready  <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                m_ready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 3) == 0) rx_stall <= idle_length();
            end
        end
    end

    // Stimulus: directed table, then random phases
    initial begin
        int n_items;
        int clear_odds;
        logic [LEN_W-1:0] len_sel;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_sample       <= '0;
        s_first_sample <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        wlen_cfg = WLEN_RESET;
        fill_n   = 0;
        head_ptr = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_window_length(directed_rows[i].wlen);
            end else begin
                send_sample(directed_rows[i].smp, directed_rows[i].first,
                            directed_rows[i].chk, directed_rows[i].want);
                idle_after_sample();
            end
        end

        foreach (phase_lengths[p]) begin
            len_sel = (p >= 7 && $urandom_range(0, 1)) ? 7'($urandom_range(0, 127))
                                                        : phase_lengths[p];
            write_window_length(len_sel);
            n_items    = (active_length() >= 32) ? 110 : 65;
            clear_odds = (active_length() >= 32) ? 300 : 50;
            repeat (n_items) begin
                send_sample(draw_sample(), $urandom_range(0, clear_odds - 1) == 0,
                            EXP_MODEL, '0);
                idle_after_sample();
            end
        end

        // Wait out the last results
        s_valid <= 1'b0;
        while (median_x2_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
